// ----- rtl/wpm_pkg.sv -----
package wpm_pkg;

    // Pattern capacity in bytes.
    localparam int MAX_PATTERN = 32;

    // One bit per pattern prefix, from the empty prefix up to the whole pattern.
    localparam int VEC_W = MAX_PATTERN + 1;
    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int ADDR_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    // Levels of the parallel prefix network that resolves runs of stars.
    localparam int PREFIX_LEVELS = (VEC_W > 1) ? $clog2(VEC_W) : 1;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    localparam logic [7:0] STAR_CHAR  = 8'd42;
    localparam logic [7:0] QMARK_CHAR = 8'd63;

    // Operation codes as they arrive on the input side.
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_TEXT   = 2'd2;
    localparam logic [1:0] OP_END    = 2'd3;

    typedef enum logic [1:0] {
        KIND_CLEAR,
        KIND_APPEND,
        KIND_TEXT,
        KIND_END
    } kind_t;

    // A classified item as it travels from the front to the back.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] ch;
        logic       is_star;
        logic       is_qmark;
    } cmd_t;

endpackage

// ----- rtl/wildcard_pattern_matcher.sv -----
// Channel  Direction  Signals                     Contents
// -------  ---------  --------------------------  ---------------------------------------
// s_*      in         s_tvalid s_tready s_tdata   tuser: op; tdata: char_in
//                     s_tuser
// m_*      out        m_tvalid m_tready m_tdata   tdata: matched, overflow (end items only)
//
// One item is taken every cycle while the output side keeps up; a text byte
// updates every pattern position at once through one prefix network per cycle.
// An end item is first held in a queue entry; the back then loads its result
// into the output register once that register is free. Reset is asynchronous
// and active low and leaves an empty pattern with no overflow. A stalled output
// makes the back refuse only end items; items behind such an item wait in the
// two-entry queue, and the input side keeps accepting until the queue is full.
module wildcard_pattern_matcher (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_in
    input  logic [1:0] s_tuser,   // [1:0] op
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] matched, [1] overflow, [7:2] zero
);
    import wpm_pkg::*;

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_ready;
    logic matched;
    logic overflow;

    // The front decodes each item and queues it.
    wpm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .in_char   (s_tdata),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // The back holds the pattern and the match column, and registers results.
    wpm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_matched  (matched),
        .out_overflow (overflow)
    );

    assign m_tdata = {6'b0, overflow, matched};

endmodule

// ----- rtl/wpm_front.sv -----
module wpm_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [1:0]    in_op,
    input  logic [7:0]    in_char,
    output logic          cmd_valid,
    input  logic          cmd_ready,
    output wpm_pkg::cmd_t cmd
);
    import wpm_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    cmd_t              classified;
    logic              push;
    logic              pop;

    // Decode the operation and flag the two wildcard bytes once, here.
    always_comb
    begin
        classified.ch       = in_char;
        classified.is_star  = (in_char == STAR_CHAR);
        classified.is_qmark = (in_char == QMARK_CHAR);
        unique case (in_op)
            OP_CLEAR:  classified.kind = KIND_CLEAR;
            OP_APPEND: classified.kind = KIND_APPEND;
            OP_TEXT:   classified.kind = KIND_TEXT;
            OP_END:    classified.kind = KIND_END;
            default:   classified.kind = KIND_END;
        endcase
    end

    assign in_ready  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

// ----- rtl/wpm_back.sv -----
module wpm_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  wpm_pkg::cmd_t cmd,
    output logic          out_valid,
    input  logic          out_ready,
    output logic          out_matched,
    output logic          out_overflow
);
    import wpm_pkg::*;

    logic [7:0]       char_reg [MAX_PATTERN];
    logic             star_reg [MAX_PATTERN];
    logic             qmark_reg [MAX_PATTERN];
    logic [LEN_W-1:0] length_reg;
    logic [LEN_W-1:0] length_next;
    logic [VEC_W-1:0] prefix_reg;
    logic [VEC_W-1:0] prefix_next;
    logic [VEC_W-1:0] empty_reg;
    logic [VEC_W-1:0] empty_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             matched_reg;
    logic             overflow_reg;
    logic             take;
    logic             store_char;
    logic [VEC_W-1:0] text_vec;
    logic [VEC_W-1:0] gen_lvl  [PREFIX_LEVELS+1];
    logic [VEC_W-1:0] prop_lvl [PREFIX_LEVELS+1];

    // Only an end item needs the output register; the rest never wait on it.
    assign cmd_ready    = (cmd.kind != KIND_END) || !out_valid_reg || out_ready;
    assign take         = cmd_valid && cmd_ready;
    assign store_char   = take && (cmd.kind == KIND_APPEND)
                          && (length_reg < LEN_W'(MAX_PATTERN));
    assign out_valid    = out_valid_reg;
    assign out_matched  = matched_reg;
    assign out_overflow = overflow_reg;

    // Column update. Each prefix position either matches on its own (generate)
    // or, for a star, takes over the new value of the prefix below (propagate).
    // The star chains are resolved by a log-depth prefix network.
    always_comb
    begin
        gen_lvl[0]  = '0;
        prop_lvl[0] = '0;
        for (int j = 1; j < VEC_W; j++)
        begin
            if (LEN_W'(j) <= length_reg)
            begin
                if (star_reg[j-1])
                begin
                    gen_lvl[0][j] = prefix_reg[j];
                end
                else
                begin
                    gen_lvl[0][j] = (qmark_reg[j-1] || (char_reg[j-1] == cmd.ch))
                                    && prefix_reg[j-1];
                end
                prop_lvl[0][j] = star_reg[j-1];
            end
        end
        for (int l = 0; l < PREFIX_LEVELS; l++)
        begin
            gen_lvl[l+1]  = gen_lvl[l];
            prop_lvl[l+1] = prop_lvl[l];
            for (int j = (1 << l); j < VEC_W; j++)
            begin
                gen_lvl[l+1][j]  = gen_lvl[l][j]
                                   || (prop_lvl[l][j] && gen_lvl[l][j - (1 << l)]);
                prop_lvl[l+1][j] = prop_lvl[l][j] && prop_lvl[l][j - (1 << l)];
            end
        end
        text_vec = gen_lvl[PREFIX_LEVELS];
    end

    always_comb
    begin
        length_next    = length_reg;
        prefix_next    = prefix_reg;
        empty_next     = empty_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (take)
        begin
            unique case (cmd.kind)
                KIND_CLEAR:
                begin
                    length_next = '0;
                    ovf_next    = 1'b0;
                    empty_next  = VEC_W'(1);
                    prefix_next = VEC_W'(1);
                end
                KIND_APPEND:
                begin
                    if (store_char)
                    begin
                        length_next = length_reg + 1'b1;
                        if (cmd.is_star && empty_reg[length_reg])
                        begin
                            empty_next[length_reg + 1'b1] = 1'b1;
                        end
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    prefix_next = empty_next;
                end
                KIND_TEXT:
                begin
                    prefix_next = text_vec;
                end
                KIND_END:
                begin
                    out_valid_next = 1'b1;
                    prefix_next    = empty_reg;
                end
                default:
                begin
                    prefix_next = prefix_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg    <= '0;
            prefix_reg    <= VEC_W'(1);
            empty_reg     <= VEC_W'(1);
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            length_reg    <= length_next;
            prefix_reg    <= prefix_next;
            empty_reg     <= empty_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_char)
        begin
            char_reg[length_reg[ADDR_W-1:0]]  <= cmd.ch;
            star_reg[length_reg[ADDR_W-1:0]]  <= cmd.is_star;
            qmark_reg[length_reg[ADDR_W-1:0]] <= cmd.is_qmark;
        end
        if (take && (cmd.kind == KIND_END))
        begin
            matched_reg  <= prefix_reg[length_reg] && !ovf_reg;
            overflow_reg <= ovf_reg;
        end
    end

endmodule

// ----- rtl/wpm_checker.sv -----
module wpm_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic [1:0] s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // An offered input item stays put until it is taken.
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
        else $error("input item changed while stalled");

    // A result that is waiting stays offered.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // A pattern that overflowed never reports a match.
    a_no_match_on_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("match reported with overflow");

    // Padding bits stay clear.
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:2] == 6'd0))
        else $error("padding bits set");

    // No result can be ready in the first cycle after reset.
    a_quiet_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !m_tvalid)
        else $error("result straight out of reset");

endmodule

bind wildcard_pattern_matcher wpm_checker u_wpm_checker (.*);

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps

// Self-checking bench for the glob-style matcher.
//
// An initial block queues every input item up front: a short directed
// opening, then random scenes.  A scene loads a pattern (usually after a
// clear) and then sends several texts that are mostly derived from that
// pattern, so that the matcher is driven well past its first prefix
// positions.  A few texts are mutated, run on into the next one, or are cut
// short by a clear or an append.
//
// The driver presents the queued items on the input stream and runs the
// bench's own model of the matcher on each item as it is accepted.  Every
// end-of-text item leaves one expected verdict behind.  The monitor takes
// result items off the output stream and checks them against the oldest
// verdict still outstanding.  Both sides draw a random wait for every item.
// Both also have stretches with no waiting at all.  A separate process makes
// the receiver hold off for long stretches so that the matcher's small
// queue fills and the input stream stalls.
module tb_top;

    import wpm_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned RANDOM_ITEMS = 2000;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned HOLD_CYCLES  = 500;

    // One input item: the operation travels in tuser, the byte in tdata.
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] ch;
    } glob_item_t;

    // One result item, as carried in the low bits of m_tdata.
    typedef struct packed {
        logic matched;
        logic overflow;
    } glob_verdict_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'd0;   // [7:0] char_in
    logic [1:0] s_tuser = 2'd0;   // [1:0] op
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;          // [0] matched, [1] overflow, [7:2] zero

    wildcard_pattern_matcher dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Items still to be sent, and verdicts still to arrive.
    glob_item_t    pending_items[$];
    glob_verdict_t expected_verdicts[$];

    // The bench's own copy of the matcher state.  Bit j of live_prefixes is
    // set while the first j pattern bytes match all of the text so far.
    // star_prefixes is the same column for an empty text, so bit j is set
    // when the first j pattern bytes are all stars.
    logic [7:0]       pattern_bytes[MAX_PATTERN];
    int unsigned      pattern_len = 0;
    logic [VEC_W-1:0] live_prefixes = VEC_W'(1);
    logic [VEC_W-1:0] star_prefixes = VEC_W'(1);
    logic             pattern_overflow = 1'b0;

    int unsigned items_taken = 0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;
    int unsigned holds_done = 0;
    int unsigned cycle_count = 0;
    int unsigned fault_count = 0;
    int unsigned verdicts_checked = 0;
    int unsigned verdicts_matched = 0;
    int unsigned verdicts_overflowed = 0;
    logic        receiver_hold;

    // Advances the model by one accepted item.  An end-of-text item queues
    // its verdict and rearms the column for the next text.
    function automatic void glob_step(input logic [1:0] op, input logic [7:0] ch);
        logic [VEC_W-1:0] next_col;
        glob_verdict_t    verdict;
        case (op)
            OP_CLEAR:
            begin
                pattern_len      = 0;
                pattern_overflow = 1'b0;
                star_prefixes    = VEC_W'(1);
                live_prefixes    = VEC_W'(1);
            end
            OP_APPEND:
            begin
                // A byte appended to a full pattern is lost, and the pattern
                // can no longer match until it is cleared.
                if (pattern_len >= MAX_PATTERN)
                begin
                    pattern_overflow = 1'b1;
                end
                else
                begin
                    pattern_bytes[pattern_len] = ch;
                    if (ch == STAR_CHAR && star_prefixes[pattern_len])
                    begin
                        star_prefixes[pattern_len + 1] = 1'b1;
                    end
                    pattern_len++;
                end
                // Appending abandons any text in progress.
                live_prefixes = star_prefixes;
            end
            OP_TEXT:
            begin
                // The empty prefix never matches a non-empty text.  A star
                // either absorbs this byte or matches an empty run after the
                // prefix before it.
                next_col = '0;
                for (int j = 1; j <= pattern_len; j++)
                begin
                    if (pattern_bytes[j - 1] == STAR_CHAR)
                    begin
                        next_col[j] = live_prefixes[j] | next_col[j - 1];
                    end
                    else if (pattern_bytes[j - 1] == QMARK_CHAR || pattern_bytes[j - 1] == ch)
                    begin
                        next_col[j] = live_prefixes[j - 1];
                    end
                end
                live_prefixes = next_col;
            end
            default:
            begin
                verdict.matched  = live_prefixes[pattern_len] & ~pattern_overflow;
                verdict.overflow = pattern_overflow;
                expected_verdicts.push_back(verdict);
                live_prefixes = star_prefixes;
            end
        endcase
    endfunction

    function automatic void queue_item(input logic [1:0] op, input logic [7:0] ch);
        glob_item_t it;
        it.op = op;
        it.ch = ch;
        pending_items.push_back(it);
    endfunction

    // Pattern bytes lean towards a small alphabet and the two wildcards, so
    // that derived texts often match.  Some bytes are fully random.
    function automatic logic [7:0] pick_pattern_byte();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            return 8'h61 + 8'($urandom_range(0, 1));
        end
        else if (r < 60)
        begin
            return STAR_CHAR;
        end
        else if (r < 75)
        begin
            return QMARK_CHAR;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_text_byte();
        if ($urandom_range(0, 3) != 0)
        begin
            return 8'h61 + 8'($urandom_range(0, 2));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // One scene: an optional clear, a pattern of the given length, and a few
    // texts built from that pattern with some damage and interruptions.
    function automatic void queue_scene(input int unsigned plen);
        logic [7:0]  pat[$];
        logic [7:0]  txt[$];
        logic [7:0]  c;
        int unsigned n_texts;
        int unsigned run;
        int unsigned idx;
        if ($urandom_range(0, 9) != 0)
        begin
            queue_item(OP_CLEAR, 8'($urandom_range(0, 255)));
        end
        for (int i = 0; i < plen; i++)
        begin
            c = pick_pattern_byte();
            queue_item(OP_APPEND, c);
            pat.push_back(c);
        end
        n_texts = $urandom_range(1, 4);
        for (int t = 0; t < n_texts; t++)
        begin
            txt.delete();
            for (int i = 0; i < pat.size() && i < MAX_PATTERN; i++)
            begin
                if (pat[i] == STAR_CHAR)
                begin
                    run = $urandom_range(0, 3);
                    for (int k = 0; k < run; k++)
                    begin
                        txt.push_back(pick_text_byte());
                    end
                end
                else if (pat[i] == QMARK_CHAR)
                begin
                    txt.push_back(pick_text_byte());
                end
                else
                begin
                    txt.push_back(pat[i]);
                end
            end
            // Damage about a third of the texts by one byte.
            if ($urandom_range(0, 2) == 0)
            begin
                if (txt.size() != 0)
                begin
                    idx = $urandom_range(0, txt.size() - 1);
                    txt[idx] = pick_text_byte();
                end
                else
                begin
                    txt.push_back(pick_text_byte());
                end
            end
            for (int i = 0; i < txt.size(); i++)
            begin
                queue_item(OP_TEXT, txt[i]);
                // Now and then the pattern changes under a running text.
                if ($urandom_range(0, 59) == 0)
                begin
                    c = pick_pattern_byte();
                    queue_item(OP_APPEND, c);
                    pat.push_back(c);
                end
                else if ($urandom_range(0, 119) == 0)
                begin
                    queue_item(OP_CLEAR, 8'($urandom_range(0, 255)));
                    pat.delete();
                end
            end
            // Most texts are closed; the rest run on into the next one.
            if ($urandom_range(0, 11) != 0)
            begin
                queue_item(OP_END, 8'($urandom_range(0, 255)));
            end
        end
    endfunction

    // Driver: presents queued items, holds each one until it is taken, and
    // steps the model at the edge where it is taken.  A random gap follows
    // each item, except in every third stretch of 128 items.
    always @(posedge clk)
    begin
        glob_item_t next_item;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                glob_step(s_tuser, s_tdata);
                items_taken <= items_taken + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    next_item = pending_items.pop_front();
                    s_tuser  <= next_item.op;
                    s_tdata  <= next_item.ch;
                    s_tvalid <= 1'b1;
                    gap_left <= ((items_taken / 128) % 3 == 1) ? 0 : $urandom_range(0, 15);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Twice during the run the receiver stops taking results for a long
    // stretch while the sender carries on.
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (holds_done < 2 && items_taken >= 400 + 800 * holds_done)
        begin
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    assign receiver_hold = (hold_left != 0);

    // Monitor: checks each result item against the oldest outstanding
    // verdict and draws a fresh stall for the next one.
    always @(posedge clk)
    begin
        glob_verdict_t want;
        int unsigned   stall_next;
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            stall_next = stall_left;
            if (m_tvalid && m_tready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    $error("tb_top: result item with no verdict outstanding, m_tdata=%h",
                           m_tdata);
                    fault_count++;
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    verdicts_checked++;
                    if (want.matched)
                    begin
                        verdicts_matched++;
                    end
                    if (want.overflow)
                    begin
                        verdicts_overflowed++;
                    end
                    if (m_tdata[0] !== want.matched)
                    begin
                        $error("tb_top: matched expected %b, got %b", want.matched, m_tdata[0]);
                        fault_count++;
                    end
                    if (m_tdata[1] !== want.overflow)
                    begin
                        $error("tb_top: overflow expected %b, got %b", want.overflow,
                               m_tdata[1]);
                        fault_count++;
                    end
                    if (m_tdata[7:2] !== 6'd0)
                    begin
                        $error("tb_top: padding expected %h, got %h", 6'd0, m_tdata[7:2]);
                        fault_count++;
                    end
                end
                stall_next = ((verdicts_checked / 32) % 3 == 1) ? 0 : $urandom_range(0, 15);
            end
            else if (stall_next != 0)
            begin
                stall_next--;
            end
            stall_left <= stall_next;
            m_tready   <= (stall_next == 0) && !receiver_hold;
        end
    end

    // The run is cut off if it takes far longer than the slowest correct run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top: timed out after %0d cycles", cycle_count);
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial
    begin
        // Directed opening.  An empty pattern matches only an empty text.
        queue_item(OP_END, 8'h00);
        queue_item(OP_TEXT, 8'h61);
        queue_item(OP_END, 8'hFF);
        // A lone star matches the empty text and any run, whatever the bytes.
        queue_item(OP_APPEND, STAR_CHAR);
        queue_item(OP_END, 8'h00);
        queue_item(OP_TEXT, 8'h00);
        queue_item(OP_TEXT, 8'hFF);
        queue_item(OP_END, 8'h00);
        // "a?*b": the question mark needs exactly one byte.
        queue_item(OP_CLEAR, 8'hFF);
        queue_item(OP_APPEND, 8'h61);
        queue_item(OP_APPEND, QMARK_CHAR);
        queue_item(OP_APPEND, STAR_CHAR);
        queue_item(OP_APPEND, 8'h62);
        queue_item(OP_TEXT, 8'h61);
        queue_item(OP_TEXT, 8'hFF);
        queue_item(OP_TEXT, 8'h62);
        queue_item(OP_END, 8'h00);
        queue_item(OP_TEXT, 8'h61);
        queue_item(OP_TEXT, 8'h62);
        queue_item(OP_END, 8'h00);
        // An append in the middle of a text abandons it; the empty text that
        // follows cannot match a pattern with literals in it.
        queue_item(OP_TEXT, 8'h61);
        queue_item(OP_APPEND, 8'h63);
        queue_item(OP_END, 8'h00);

        // Random part.  The first scenes overfill the pattern and then fill
        // it exactly.
        queue_scene(MAX_PATTERN + 3);
        queue_scene(MAX_PATTERN);
        while (pending_items.size() < RANDOM_ITEMS + 24)
        begin
            int unsigned r;
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                queue_scene($urandom_range(0, 6));
            end
            else if (r < 90)
            begin
                queue_scene($urandom_range(7, 16));
            end
            else if (r < 98)
            begin
                queue_scene($urandom_range(17, MAX_PATTERN));
            end
            else
            begin
                queue_scene($urandom_range(MAX_PATTERN + 1, MAX_PATTERN + 8));
            end
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || s_tvalid)
        begin
            @(posedge clk);
        end
        while (expected_verdicts.size() != 0)
        begin
            @(posedge clk);
        end
        // Give a stray extra result the chance to show itself.
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb_top: %0d items sent, %0d end-of-text verdicts checked", items_taken,
                 verdicts_checked);
        $display("tb_top: %0d verdicts matched, %0d reported pattern overflow",
                 verdicts_matched, verdicts_overflowed);
        if (fault_count == 0)
        begin
            $display("tb_top: done, clean");
        end
        else
        begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
